// ----- rtl/core/prc_pkg.sv -----
`default_nettype none
package prc_pkg;

    // Data set limits and accumulator widths
    localparam int MAX_PAIRS = 1024;
    localparam int CNT_W     = 11;
    localparam int SUM_W     = 26;
    localparam int SQ_W      = 41;
    localparam int XY_W      = 42;

    // Back end arithmetic widths
    localparam int OPW   = 52;          // multiplier and divider operand magnitude
    localparam int PRW   = 2 * OPW;     // product width
    localparam int VW    = 54;          // signed variance and covariance terms
    localparam int DNW   = OPW + 16;    // shifted dividend
    localparam int QW    = 34;          // quotient bits kept
    localparam int RW    = OPW + 1;     // divider remainder
    localparam int SPW   = 102;         // radicand
    localparam int SRW   = SPW / 2;     // root
    localparam int SREMW = SRW + 4;     // root remainder
    localparam int SEQ_W = 7;           // step counter

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_XVAR  = 2'd1;
    localparam logic [1:0] STATUS_YVAR  = 2'd2;
    localparam logic [1:0] STATUS_OVFL  = 2'd3;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic               last_pair;
    } prc_sample_t;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [15:0] correlation;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic [10:0]        pair_count;
        logic [1:0]         status;
    } prc_result_t;

    // Sums of one finished data set, handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]         sum_xx;
        logic [SQ_W-1:0]         sum_yy;
        logic signed [XY_W-1:0]  sum_xy;
        logic                    ovfl;
    } prc_snap_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MXX_A,
        S_MXX_B,
        S_MYY_A,
        S_MYY_B,
        S_MXY_A,
        S_MXY_B,
        S_MEAN_X,
        S_MEAN_Y,
        S_SLOPE,
        S_ICPT,
        S_PVAR,
        S_SQRT,
        S_CORR,
        S_OUT
    } prc_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/prc_front.sv -----
`default_nettype none
module prc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire prc_pkg::prc_sample_t sample,
    input  wire logic               q_full,
    output logic                    q_push,
    output prc_pkg::prc_snap_t      q_data
);
    import prc_pkg::*;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [SQ_W-1:0]         sum_xx_reg, sum_xx_next;
    logic [SQ_W-1:0]         sum_yy_reg, sum_yy_next;
    logic signed [XY_W-1:0]  sum_xy_reg, sum_xy_next;
    logic                    ovfl_reg, ovfl_next;

    logic               accept;
    logic signed [31:0] prod_xx, prod_yy, prod_xy;

    assign sample_ready = !q_full;
    assign accept       = sample_valid && sample_ready;

    assign prod_xx = sample.x_value * sample.x_value;
    assign prod_yy = sample.y_value * sample.y_value;
    assign prod_xy = sample.x_value * sample.y_value;

    // Accumulate or drop the pair, then hand the set over on the last one
    always_comb
    begin
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_yy_next = sum_yy_reg;
        sum_xy_next = sum_xy_reg;
        ovfl_next   = ovfl_reg;
        if (accept)
        begin
            if (count_reg < CNT_W'(MAX_PAIRS))
            begin
                count_next  = count_reg + 1'b1;
                sum_x_next  = sum_x_reg + SUM_W'(sample.x_value);
                sum_y_next  = sum_y_reg + SUM_W'(sample.y_value);
                sum_xx_next = sum_xx_reg + SQ_W'(unsigned'(prod_xx));
                sum_yy_next = sum_yy_reg + SQ_W'(unsigned'(prod_yy));
                sum_xy_next = sum_xy_reg + XY_W'(prod_xy);
            end
            else
            begin
                ovfl_next = 1'b1;
            end
        end
        q_push = accept && sample.last_pair;
        q_data = '{count: count_next, sum_x: sum_x_next, sum_y: sum_y_next,
                   sum_xx: sum_xx_next, sum_yy: sum_yy_next,
                   sum_xy: sum_xy_next, ovfl: ovfl_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            ovfl_reg   <= 1'b0;
        end
        else if (q_push)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            ovfl_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_xx_reg <= sum_xx_next;
            sum_yy_reg <= sum_yy_next;
            sum_xy_reg <= sum_xy_next;
            ovfl_reg   <= ovfl_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/prc_queue.sv -----
`default_nettype none
module prc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire prc_pkg::prc_snap_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output prc_pkg::prc_snap_t      head
);
    import prc_pkg::*;

    prc_snap_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // Store a set at the write pointer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/prc_back.sv -----
`default_nettype none
module prc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire prc_pkg::prc_snap_t q_head,
    output logic                    q_pop,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output prc_pkg::prc_result_t    result
);
    import prc_pkg::*;

    prc_state_t state_reg, state_next;
    logic       busy_reg, busy_next;
    logic [SEQ_W-1:0] cnt_reg, cnt_next;
    prc_snap_t  snap_reg, snap_next;

    // Shift-add multiplier
    logic [PRW-1:0] ma_reg, ma_next;
    logic [OPW-1:0] mb_reg, mb_next;
    logic [PRW-1:0] macc_reg, macc_next;

    // Restoring divider
    logic [DNW-1:0] dnum_reg, dnum_next;
    logic [RW-1:0]  drem_reg, drem_next;
    logic [OPW-1:0] dden_reg, dden_next;
    logic [QW-1:0]  dq_reg, dq_next;
    logic           dovf_reg, dovf_next;

    // Digit-by-digit square root
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [SRW-1:0]   sroot_reg, sroot_next;
    logic [SREMW-1:0] srem_reg, srem_next;

    logic signed [VW-1:0] tprod_reg, tprod_next;
    logic signed [VW-1:0] sxx_reg, sxx_next;
    logic signed [VW-1:0] syy_reg, syy_next;
    logic signed [VW-1:0] sxy_reg, sxy_next;
    logic signed [31:0]   slope_reg, slope_next;
    logic signed [31:0]   icpt_reg, icpt_next;
    logic signed [15:0]   corr_reg, corr_next;
    logic signed [31:0]   mx_reg, mx_next;
    logic signed [31:0]   my_reg, my_next;
    logic [1:0]           status_reg, status_next;
    prc_result_t          res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    logic [OPW-1:0] mul_a, mul_b, div_num, div_den;
    logic           mul_neg, div_neg, div_q16;
    logic           is_mul, is_div;

    logic [OPW-1:0]       mag_sx, mag_sy, mag_sxy_sum, mag_sxy, mag_slope, mag_mx;
    logic signed [VW-1:0] prod_val;
    logic [RW-1:0]        div_sh;
    logic [SREMW-1:0]     sq_sh, sq_trial;
    logic [46:0]          icpt_tm;
    logic signed [48:0]   icpt_diff;
    logic signed [31:0]   q16_val;
    logic signed [15:0]   q15_val;
    logic                 sxx_zero, syy_zero;

    function automatic logic [OPW-1:0] mag_of(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] m;
        m = v[VW-1] ? -v : v;
        return m[OPW-1:0];
    endfunction

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Operand magnitudes
    always_comb
    begin
        mag_sx      = mag_of(VW'(snap_reg.sum_x));
        mag_sy      = mag_of(VW'(snap_reg.sum_y));
        mag_sxy_sum = mag_of(VW'(snap_reg.sum_xy));
        mag_sxy     = mag_of(sxy_reg);
        mag_slope   = mag_of(VW'(slope_reg));
        mag_mx      = mag_of(VW'(mx_reg));
        sxx_zero    = sxx_reg[VW-1] || (sxx_reg == '0);
        syy_zero    = syy_reg[VW-1] || (syy_reg == '0);
    end

    // Pick unit and operands for the current step
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        div_num = '0;
        div_den = '0;
        div_neg = 1'b0;
        div_q16 = 1'b1;
        is_mul  = 1'b0;
        is_div  = 1'b0;
        case (state_reg)
            S_MXX_A:
            begin
                is_mul = 1'b1;
                mul_a  = OPW'(snap_reg.count);
                mul_b  = OPW'(snap_reg.sum_xx);
            end
            S_MXX_B:
            begin
                is_mul = 1'b1;
                mul_a  = mag_sx;
                mul_b  = mag_sx;
            end
            S_MYY_A:
            begin
                is_mul = 1'b1;
                mul_a  = OPW'(snap_reg.count);
                mul_b  = OPW'(snap_reg.sum_yy);
            end
            S_MYY_B:
            begin
                is_mul = 1'b1;
                mul_a  = mag_sy;
                mul_b  = mag_sy;
            end
            S_MXY_A:
            begin
                is_mul  = 1'b1;
                mul_a   = OPW'(snap_reg.count);
                mul_b   = mag_sxy_sum;
                mul_neg = snap_reg.sum_xy[XY_W-1];
            end
            S_MXY_B:
            begin
                is_mul  = 1'b1;
                mul_a   = mag_sx;
                mul_b   = mag_sy;
                mul_neg = snap_reg.sum_x[SUM_W-1] ^ snap_reg.sum_y[SUM_W-1];
            end
            S_ICPT:
            begin
                is_mul  = 1'b1;
                mul_a   = mag_slope;
                mul_b   = mag_mx;
                mul_neg = slope_reg[31] ^ mx_reg[31];
            end
            S_PVAR:
            begin
                is_mul = 1'b1;
                mul_a  = sxx_reg[OPW-1:0];
                mul_b  = syy_reg[OPW-1:0];
            end
            S_MEAN_X:
            begin
                is_div  = 1'b1;
                div_num = mag_sx;
                div_den = OPW'(snap_reg.count);
                div_neg = snap_reg.sum_x[SUM_W-1];
            end
            S_MEAN_Y:
            begin
                is_div  = 1'b1;
                div_num = mag_sy;
                div_den = OPW'(snap_reg.count);
                div_neg = snap_reg.sum_y[SUM_W-1];
            end
            S_SLOPE:
            begin
                is_div  = 1'b1;
                div_num = mag_sxy;
                div_den = sxx_reg[OPW-1:0];
                div_neg = sxy_reg[VW-1];
            end
            S_CORR:
            begin
                is_div  = 1'b1;
                div_num = mag_sxy;
                div_den = OPW'(sroot_reg);
                div_neg = sxy_reg[VW-1];
                div_q16 = 1'b0;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    // Finished-unit results
    always_comb
    begin
        prod_val  = mul_neg ? -macc_reg[VW-1:0] : macc_reg[VW-1:0];
        icpt_tm   = macc_reg[62:16];
        icpt_diff = 49'(my_reg) - (mul_neg ? -49'(icpt_tm) : 49'(icpt_tm));
        // Saturated Q16.16 quotient
        if (div_neg)
        begin
            q16_val = (dovf_reg || dq_reg > QW'(33'h080000000)) ? 32'sh80000000
                                                               : -dq_reg[31:0];
        end
        else
        begin
            q16_val = (dovf_reg || dq_reg > QW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                              : dq_reg[31:0];
        end
        // Saturated Q1.15 quotient
        if (div_neg)
        begin
            q15_val = (dovf_reg || dq_reg > QW'(16'h8000)) ? 16'sh8000 : -dq_reg[15:0];
        end
        else
        begin
            q15_val = (dovf_reg || dq_reg > QW'(16'h7FFF)) ? 16'sh7FFF : dq_reg[15:0];
        end
        div_sh   = {drem_reg[RW-2:0], dnum_reg[DNW-1]};
        sq_sh    = {srem_reg[SREMW-3:0], sp_reg[SPW-1:SPW-2]};
        sq_trial = SREMW'({sroot_reg, 2'b01});
    end

    // Sequencer and shared units
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        snap_next      = snap_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        macc_next      = macc_reg;
        dnum_next      = dnum_reg;
        drem_next      = drem_reg;
        dden_next      = dden_reg;
        dq_next        = dq_reg;
        dovf_next      = dovf_reg;
        sp_next        = sp_reg;
        sroot_next     = sroot_reg;
        srem_next      = srem_reg;
        tprod_next     = tprod_reg;
        sxx_next       = sxx_reg;
        syy_next       = syy_reg;
        sxy_next       = sxy_reg;
        slope_next     = slope_reg;
        icpt_next      = icpt_reg;
        corr_next      = corr_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    snap_next   = q_head;
                    slope_next  = '0;
                    icpt_next   = '0;
                    corr_next   = '0;
                    mx_next     = '0;
                    my_next     = '0;
                    status_next = STATUS_OK;
                    busy_next   = 1'b0;
                    state_next  = S_MXX_A;
                end
            end
            S_SQRT:
            begin
                if (!busy_reg)
                begin
                    sroot_next = '0;
                    srem_next  = '0;
                    cnt_next   = '0;
                    busy_next  = 1'b1;
                end
                else if (cnt_reg != SEQ_W'(SRW))
                begin
                    // One root bit per step
                    if (sq_sh >= sq_trial)
                    begin
                        srem_next  = sq_sh - sq_trial;
                        sroot_next = {sroot_reg[SRW-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_next  = sq_sh;
                        sroot_next = {sroot_reg[SRW-2:0], 1'b0};
                    end
                    sp_next  = {sp_reg[SPW-3:0], 2'b00};
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    busy_next  = 1'b0;
                    state_next = S_CORR;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next = '{slope: slope_reg, intercept: icpt_reg,
                                 correlation: corr_reg, mean_x: mx_reg, mean_y: my_reg,
                                 pair_count: snap_reg.count, status: status_reg};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                if (is_mul)
                begin
                    if (!busy_reg)
                    begin
                        ma_next   = PRW'(mul_a);
                        mb_next   = mul_b;
                        macc_next = '0;
                        cnt_next  = '0;
                        busy_next = 1'b1;
                    end
                    else if (cnt_reg != SEQ_W'(OPW))
                    begin
                        if (mb_reg[0])
                        begin
                            macc_next = macc_reg + ma_reg;
                        end
                        ma_next  = {ma_reg[PRW-2:0], 1'b0};
                        mb_next  = {1'b0, mb_reg[OPW-1:1]};
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        case (state_reg)
                            S_MXX_A:
                            begin
                                tprod_next = prod_val;
                                state_next = S_MXX_B;
                            end
                            S_MXX_B:
                            begin
                                sxx_next   = tprod_reg - prod_val;
                                state_next = S_MYY_A;
                            end
                            S_MYY_A:
                            begin
                                tprod_next = prod_val;
                                state_next = S_MYY_B;
                            end
                            S_MYY_B:
                            begin
                                syy_next   = tprod_reg - prod_val;
                                state_next = S_MXY_A;
                            end
                            S_MXY_A:
                            begin
                                tprod_next = prod_val;
                                state_next = S_MXY_B;
                            end
                            S_MXY_B:
                            begin
                                sxy_next = tprod_reg - prod_val;
                                if (snap_reg.ovfl)
                                begin
                                    status_next = STATUS_OVFL;
                                    state_next  = S_OUT;
                                end
                                else
                                begin
                                    state_next = S_MEAN_X;
                                end
                            end
                            S_ICPT:
                            begin
                                if (icpt_diff > 49'sh0007FFFFFFF)
                                begin
                                    icpt_next = 32'sh7FFFFFFF;
                                end
                                else if (icpt_diff < -49'sh00080000000)
                                begin
                                    icpt_next = 32'sh80000000;
                                end
                                else
                                begin
                                    icpt_next = icpt_diff[31:0];
                                end
                                if (syy_zero)
                                begin
                                    status_next = STATUS_YVAR;
                                    state_next  = S_OUT;
                                end
                                else
                                begin
                                    state_next = S_PVAR;
                                end
                            end
                            default:
                            begin
                                sp_next    = macc_reg[SPW-1:0];
                                state_next = S_SQRT;
                            end
                        endcase
                    end
                end
                else if (is_div)
                begin
                    if (!busy_reg)
                    begin
                        dnum_next = div_q16 ? {div_num, 16'b0} : {1'b0, div_num, 15'b0};
                        drem_next = '0;
                        dden_next = div_den;
                        dq_next   = '0;
                        dovf_next = 1'b0;
                        cnt_next  = '0;
                        busy_next = 1'b1;
                    end
                    else if (cnt_reg != SEQ_W'(DNW))
                    begin
                        // One quotient bit per step
                        if (div_sh >= {1'b0, dden_reg})
                        begin
                            drem_next = div_sh - {1'b0, dden_reg};
                            dq_next   = {dq_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_next = div_sh;
                            dq_next   = {dq_reg[QW-2:0], 1'b0};
                        end
                        dovf_next = dovf_reg || dq_reg[QW-1];
                        dnum_next = {dnum_reg[DNW-2:0], 1'b0};
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        case (state_reg)
                            S_MEAN_X:
                            begin
                                mx_next    = (snap_reg.count == '0) ? '0 : q16_val;
                                state_next = S_MEAN_Y;
                            end
                            S_MEAN_Y:
                            begin
                                my_next = (snap_reg.count == '0) ? '0 : q16_val;
                                if (sxx_zero)
                                begin
                                    status_next = STATUS_XVAR;
                                    state_next  = S_OUT;
                                end
                                else
                                begin
                                    state_next = S_SLOPE;
                                end
                            end
                            S_SLOPE:
                            begin
                                slope_next = q16_val;
                                state_next = S_ICPT;
                            end
                            default:
                            begin
                                corr_next  = q15_val;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        snap_reg   <= snap_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        macc_reg   <= macc_next;
        dnum_reg   <= dnum_next;
        drem_reg   <= drem_next;
        dden_reg   <= dden_next;
        dq_reg     <= dq_next;
        dovf_reg   <= dovf_next;
        sp_reg     <= sp_next;
        sroot_reg  <= sroot_next;
        srem_reg   <= srem_next;
        tprod_reg  <= tprod_next;
        sxx_reg    <= sxx_next;
        syy_reg    <= syy_next;
        sxy_reg    <= sxy_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        corr_reg   <= corr_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/paired_regression_correlation_core.sv -----
// Least-squares line of y on x and Pearson correlation over a stream of
// sample pairs.
// Sample channel (sample_valid/sample_ready/sample): one signed (x, y) pair a
// request; last_pair closes the data set. Pairs are summed at one per cycle
// while the queue has room. A pair beyond 1024 in one set is dropped and
// flags the set as overflowed.
// Result channel (result_valid/result_ready/result): one request per data set
// carrying slope, intercept, r, both means, the pair count and a status.
// The back end works through one set at a time with a shared shift-add
// multiplier, a restoring divider and a square-root unit, one bit a cycle.
// Two finished sets can wait between the front and back end; while both
// slots are taken sample_ready stays low for every pair.
// A stalled receiver holds the result register; the back end then waits and
// the front keeps accepting pairs until the queue fills.
// Reset clears the running sums, empties the queue and drops any pending result.
`default_nettype none
module paired_regression_correlation_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire prc_pkg::prc_sample_t sample,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output prc_pkg::prc_result_t      result
);
    import prc_pkg::*;

    logic      q_full, q_push, q_pop, q_valid;
    prc_snap_t q_in, q_head;

    prc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    prc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    prc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire
